FILE: hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion %s failed", "lbl");
// Checks that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion %s failed", "lbl");
`else
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: hdl/b64d_pkg.sv
// Shared types, constants and the character classifier of the decoder.
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;  // '='
    localparam logic [7:0] CHAR_SPACE   = 8'h20;  // ' '
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // '\n'
    localparam logic [5:0] SEXTET_62    = 6'd62;
    localparam logic [5:0] SEXTET_63    = 6'd63;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       last;
        logic       kept;    // not padding, space or newline
        logic       valid;   // character belongs to one of the alphabets
        logic [5:0] sextet;
    } b64d_item_t;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end else if (c == 8'h2B || c == 8'h2D) begin
            r = {1'b1, SEXTET_62};
        end else if (c == 8'h2F || c == 8'h5F) begin
            r = {1'b1, SEXTET_63};
        end
        return r;
    endfunction

endpackage

FILE: hdl/b64d_front.sv
// Front end: accepts characters and classifies them for the queue.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_char[7:0]
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output b64d_item_t q_item
);

    logic [6:0] cls;

    always_comb begin
        cls              = sextet_of(s_tdata);
        q_item.last      = s_tlast;
        q_item.kept      = (s_tdata != CHAR_PAD) && (s_tdata != CHAR_SPACE) &&
                           (s_tdata != CHAR_NEWLINE);
        q_item.valid     = cls[6];
        q_item.sextet    = cls[5:0];
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

FILE: hdl/b64d_queue.sv
// Short queue of classified characters between the front and the back.
module b64d_queue
    import b64d_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  b64d_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output b64d_item_t head_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    b64d_item_t    slots_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_item = slots_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = do_push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = CW'(fill_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            fill_next = CW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/b64d_back.sv
// Back end: bit window, counters, end-of-string report and output register.
module b64d_back
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] byte_limit,
    input  logic        q_not_empty,
    input  b64d_item_t  q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam int WIDE = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [12:0]            window_reg, window_next;
    logic [3:0]             held_reg, held_next;
    logic [COUNT_WIDTH-1:0] emitted_reg, emitted_next;
    logic [COUNT_WIDTH-1:0] chars_reg, chars_next;
    logic [COUNT_WIDTH-1:0] kept_reg, kept_next;

    logic                   out_valid_reg;
    logic [7:0]             out_byte_reg, out_byte_next;
    logic                   byte_valid_reg, byte_valid_next;
    logic                   done_reg;
    logic                   ovf_reg, ovf_next;
    logic [15:0]            count_reg, count_next;

    logic [12:0]            shifted;
    logic [3:0]             held_sum;
    logic [3:0]             held_rem;
    logic [12:0]            rem_mask;
    logic [COUNT_WIDTH+1:0] kept_x3;
    logic [WIDE-1:0]        need_w;
    logic [WIDE-1:0]        emitted_w;
    logic                   produce;

    assign q_pop = q_not_empty && (!out_valid_reg || m_tready);

    always_comb begin
        chars_next = (chars_reg != '1) ? COUNT_WIDTH'(chars_reg + 1'b1) : chars_reg;
        kept_next  = q_item.kept ? chars_next : kept_reg;

        shifted  = {window_reg[6:0], q_item.sextet};
        held_sum = held_reg + 4'd6;
        held_rem = held_sum - 4'd8;
        rem_mask = 13'((13'd1 << held_rem) - 13'd1);

        window_next     = window_reg;
        held_next       = held_reg;
        emitted_next    = emitted_reg;
        byte_valid_next = 1'b0;
        out_byte_next   = 8'd0;
        if (q_item.valid) begin
            window_next = shifted;
            held_next   = held_sum;
            if (held_sum >= 4'd8) begin
                held_next       = held_rem;
                out_byte_next   = 8'(shifted >> held_rem);
                window_next     = shifted & rem_mask;
                byte_valid_next = 1'b1;
                if (emitted_reg != '1) begin
                    emitted_next = COUNT_WIDTH'(emitted_reg + 1'b1);
                end
            end
        end

        // Required length is floor(3 * kept / 4), formed as kept + 2 * kept.
        kept_x3   = {2'b00, kept_next} + {1'b0, kept_next, 1'b0};
        need_w    = WIDE'(kept_x3[COUNT_WIDTH+1:2]);
        emitted_w = WIDE'(emitted_next);

        ovf_next   = 1'b0;
        count_next = 16'd0;
        if (q_item.last) begin
            ovf_next = (byte_limit == 16'd0) || (need_w > WIDE'(byte_limit)) ||
                       (chars_next == '1);
            count_next = (emitted_w > WIDE'(16'hFFFF)) ? 16'hFFFF : emitted_w[15:0];
        end

        produce = byte_valid_next || q_item.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= '0;
            held_reg      <= '0;
            emitted_reg   <= '0;
            chars_reg     <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                if (q_item.last) begin
                    window_reg  <= '0;
                    held_reg    <= '0;
                    emitted_reg <= '0;
                    chars_reg   <= '0;
                    kept_reg    <= '0;
                end else begin
                    window_reg  <= window_next;
                    held_reg    <= held_next;
                    emitted_reg <= emitted_next;
                    chars_reg   <= chars_next;
                    kept_reg    <= kept_next;
                end
            end
            if (q_pop && produce) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && produce) begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            done_reg       <= q_item.last;
            ovf_reg        <= ovf_next;
            count_reg      <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {count_reg, out_byte_reg};
    assign m_tuser  = {ovf_reg, byte_valid_reg};
    assign m_tlast  = done_reg;

endmodule

FILE: hdl/base64_stream_decoder_unit.sv
// Top level of the streaming Base64 / Base64url decoder.
`include "assert_macros.svh"

// Decodes one character per clock cycle while the output register is free or
// being emptied, in both the standard and the URL-safe alphabet; all other
// codes, padding included, are skipped. A byte leaves on m_* each time eight
// bits have gathered, and the character marked by s_tlast yields a report in
// the same transfer: byte count and an overflow flag raised when the byte
// limit is zero, the character count saturates, or floor(3/4 of the characters
// through the last one that is not '=', space or newline) exceeds the limit.
// The classifier feeds a four-entry queue that the bit-window stage drains;
// from input transfer to result a character passes a queue slot and the output register.
// The byte limit is written through cfg_wr_en / cfg_wr_data and resets to 65535.
module base64_stream_decoder_unit
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // byte limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // in_char[7:0]
    input  logic        s_tlast,       // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // out_byte[7:0], byte_count[23:8]
    output logic [1:0]  m_tuser,       // byte_valid[0], overflow[1]
    output logic        m_tlast        // done_res
);

    logic [15:0] byte_limit_reg;
    logic        q_full, q_push, q_pop, q_not_empty;
    b64d_item_t  push_item, head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            byte_limit_reg <= cfg_wr_data;
        end
    end

    b64d_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    b64d_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    b64d_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_limit  (byte_limit_reg),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // A result without a byte carries a zero byte field.
    `ASSERT_IMPLIES(a_zero_byte, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[7:0] == 8'd0)
    // Only the end-of-string result carries a count or an overflow flag.
    `ASSERT_IMPLIES(a_report_on_last, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[23:8] == 16'd0 && !m_tuser[1])
    // Every result carries a byte, a report, or both.
    `ASSERT_NEVER(a_no_empty_result, aclk, aresetn, m_tvalid && !m_tuser[0] && !m_tlast)

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the streaming Base64 / Base64url decoder unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import b64d_pkg::*;

    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [15:0] COUNT_SAT    = 16'hFFFF;
    localparam int SETTLE_CYCLES         = 4;
    localparam int PHASE_ITEMS           = 225;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [2:0] gap;
    } char_xfer_t;

    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done;
        logic        overflow;
    } decode_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Decoder state as the testbench sees it.
    logic [12:0] dec_window = '0;
    logic [3:0]  dec_held = '0;
    logic [15:0] dec_emitted = '0;
    logic [15:0] dec_chars = '0;
    logic [15:0] dec_kept = '0;
    logic [15:0] capacity = 16'hFFFF;

    char_xfer_t     chars_to_send[$];
    decode_result_t predicted_results[$];
    logic [7:0]     text_q[$];

    bit quiet = 1'b0;
    int items_queued = 0;
    int chars_sent = 0;
    int bytes_checked = 0;
    int reports_checked = 0;
    int fail_count = 0;
    int gap_count = 0;
    int stall_count = 0;

    always #5 aclk = ~aclk;

    base64_stream_decoder_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Bit 6 flags a character of either alphabet, bits 5:0 carry its value.
    function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] base;
        base = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            base = 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            base = 8'h61 - 8'd26;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            base = 8'h30 - 8'd52;
        end
        if (base != 8'h00) begin
            return {1'b1, 6'(c - base)};
        end
        if (c == CH_PLUS || c == CH_MINUS) begin
            return {1'b1, 6'd62};
        end
        if (c == CH_SLASH || c == CH_UNDERSCORE) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return 8'h41 + v;
        end else if (v < 6'd52) begin
            return 8'h61 + v - 8'd26;
        end else if (v < 6'd62) begin
            return 8'h30 + v - 8'd52;
        end else if (v == 6'd62) begin
            return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
        end
        return $urandom_range(0, 1) ? CH_SLASH : CH_UNDERSCORE;
    endfunction

    task automatic decode_char(input logic [7:0] c, input logic last);
        logic [6:0] code;
        decode_result_t r;
        int need;
        r = '0;
        code = char_to_sextet(c);
        if (dec_chars != COUNT_SAT) begin
            dec_chars = dec_chars + 16'd1;
        end
        if (c != CHAR_PAD && c != CHAR_SPACE && c != CHAR_NEWLINE) begin
            dec_kept = dec_chars;
        end
        if (code[6]) begin
            dec_window = {dec_window[6:0], code[5:0]};
            dec_held = dec_held + 4'd6;
            if (dec_held >= 4'd8) begin
                dec_held = dec_held - 4'd8;
                r.out_byte = 8'(dec_window >> dec_held);
                r.byte_valid = 1'b1;
                dec_window = dec_window & ((13'd1 << dec_held) - 13'd1);
                if (dec_emitted != COUNT_SAT) begin
                    dec_emitted = dec_emitted + 16'd1;
                end
            end
        end
        if (last) begin
            need = (int'(dec_kept) * 3) / 4;
            r.done = 1'b1;
            r.overflow = (capacity == 16'd0) || (need > int'(capacity)) ||
                         (dec_chars == COUNT_SAT);
            r.byte_count = dec_emitted;
            dec_window = '0;
            dec_held = '0;
            dec_emitted = '0;
            dec_chars = '0;
            dec_kept = '0;
        end
        if (r.byte_valid || last) begin
            predicted_results.push_back(r);
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : drive_chars
        logic holding;
        logic next_valid;
        char_xfer_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_count = 0;
        end else begin
            holding = s_tvalid && !s_tready;
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast);
                chars_sent++;
            end
            next_valid = holding;
            if (!holding && chars_to_send.size() > 0) begin
                if (gap_count < chars_to_send[0].gap) begin
                    gap_count++;
                end else begin
                    nxt = chars_to_send.pop_front();
                    gap_count = 0;
                    s_tdata <= nxt.ch;
                    s_tlast <= nxt.last;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge aclk) begin : watch_results
        decode_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("unexpected result transfer: data %h user %b last %b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata[7:0]);
                    check_field("byte_valid", want.byte_valid, m_tuser[0]);
                    check_field("done_res", want.done, m_tlast);
                    check_field("overflow", want.overflow, m_tuser[1]);
                    check_field("byte_count", want.byte_count, m_tdata[23:8]);
                    if (want.byte_valid) bytes_checked++;
                    if (want.done) reports_checked++;
                end
                stall_count = quiet ? 0 : $urandom_range(0, 5);
            end else if (stall_count > 0) begin
                stall_count--;
            end
            m_tready <= (stall_count == 0);
        end
    end

    // Moves the gathered text into the send queue; its final character ends the string.
    task automatic flush_text();
        char_xfer_t x;
        for (int i = 0; i < text_q.size(); i++) begin
            x.ch = text_q[i];
            x.last = (i == text_q.size() - 1);
            x.gap = quiet ? 3'd0 : 3'($urandom_range(0, 5));
            chars_to_send.push_back(x);
        end
        items_queued += text_q.size();
        text_q.delete();
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (chars_to_send.size() != 0 || s_tvalid || predicted_results.size() != 0);
        // Skipped characters leave no result but may still be in the pipeline.
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        settle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        capacity = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_string();
        int kind;
        int groups;
        int pads;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            // Well-formed text: whole groups, optional padding and line breaks.
            groups = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
            for (int g = 0; g < groups; g++) begin
                for (int k = 0; k < 4; k++) begin
                    text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
                end
                if (g != groups - 1 && $urandom_range(0, 5) == 0) begin
                    text_q.push_back($urandom_range(0, 1) ? CHAR_NEWLINE : CHAR_SPACE);
                end
            end
            pads = $urandom_range(0, 2);
            for (int p = 0; p < pads; p++) begin
                text_q[text_q.size() - 1 - p] = CHAR_PAD;
            end
            if ($urandom_range(0, 5) == 0) begin
                text_q.push_back(CHAR_NEWLINE);
            end
        end else if (kind < 9) begin
            // Truncated text with stray characters mixed in.
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
                end
            end
        end else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        flush_text();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Both alphabets at their edges, closed by padding, under the reset capacity.
        text_q = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h30, 8'h39,
                   CH_PLUS, CH_MINUS, CH_SLASH, CH_UNDERSCORE, CHAR_PAD};
        flush_text();

        // Codes just outside each range, code zero, space and newline; zero capacity.
        write_capacity(16'd0);
        text_q = '{8'h00, 8'h2A, 8'h2C, 8'h2E, 8'h3A, 8'h40, 8'h5B, 8'h60,
                   8'h7B, 8'hFF, CHAR_SPACE, CHAR_NEWLINE, 8'h54, 8'h51, CHAR_NEWLINE};
        flush_text();

        for (int p = 0; p < 6; p++) begin : phase_loop
            int start;
            bit paused;
            case (p)
                0: write_capacity(16'd1);
                1: write_capacity(16'($urandom_range(2, 40)));
                2: write_capacity(16'hFFFF);
                3: write_capacity(16'($urandom_range(4, 20)));
                4: write_capacity(16'($urandom_range(0, 65535)));
                default: write_capacity(16'($urandom_range(1, 12)));
            endcase
            quiet = (p == 2);
            start = items_queued;
            paused = 1'b0;
            while (items_queued - start < PHASE_ITEMS) begin
                random_string();
                // Let the sender run dry once per phase, mid-stream.
                if (!paused && items_queued - start >= PHASE_ITEMS / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        quiet = 1'b0;
        repeat (8) @(negedge aclk);
        $display("Checked %0d characters: %0d decoded bytes and %0d end-of-string reports.",
                 chars_sent, bytes_checked, reports_checked);
        $display("Capacities 0, 1, 65535 and random values, with idle gaps and output stalls.");
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
